>>> hw/rtl/bitmap_frame_allocator_core_assert.svh
// Assertion macros used by the allocator controller.
// Each macro expects i_clk and i_rst_n in the scope of its use.
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTH

`define BFA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bitmap frame allocator assertion failed");

`define BFA_ASSERT_IMP(lbl, ante, cons) `BFA_ASSERT(lbl, (ante) |-> (cons))

`define BFA_ASSERT_NEXT(lbl, ante, cons) `BFA_ASSERT(lbl, (ante) |=> (cons))

`else

`define BFA_ASSERT(lbl, prop)

`define BFA_ASSERT_IMP(lbl, ante, cons)

`define BFA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAME_COUNT_W = 13;

    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

    // register index as decoded from the APB address
    localparam logic [0:0] REG_FRAME_COUNT = 1'b0;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] frame_addr;
    } t_in_item;

    typedef struct packed {
        logic [31:0] alloc_addr;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } t_state;

    // position of the lowest clear bit, binary search in five steps
    function automatic logic [4:0] first_zero(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] mask;
        logic [4:0]        pos;
        x   = ~word;
        pos = '0;
        for (int s = 4; s >= 0; s--) begin
            mask = (32'd1 << (1 << s)) - 32'd1;
            if ((x & mask) == 32'd0) begin
                pos = pos | 5'(1 << s);
                x   = x >> (1 << s);
            end
        end
        return pos;
    endfunction

endpackage

>>> hw/rtl/bitmap_frame_allocator_core.sv
// Physical page frame allocator, first fit over a one-bit-per-frame bitmap.
// Request channel: i_in_valid / o_in_ready carry i_in_item (opcode, frame_addr).
//   Allocate returns the byte address of the lowest free frame below the
//   active count; free and reserve clear or set the bit of the addressed frame.
// Result channel: o_out_valid / i_out_ready carry o_out_item (alloc_addr, status),
//   exactly one result per request, held in an output register.
// One request at a time. Free and reserve pass through the READ, MODIFY and DONE
//   states from accept to result, straight to DONE when the frame is out of range,
//   as for the unused opcode; an allocation reads the bitmap RAM one word per
//   cycle in SCAN until it finds a clear bit or reaches the last word.
// The next request is accepted as soon as the result has moved to the output
//   register, so a result waiting on a stalled receiver does not block it;
//   with both the output register and the engine full, o_in_ready drops.
// Reset: the engine clears every word of the bitmap RAM, one word per cycle,
//   and accepts no request meanwhile; frame_count returns to 4096.
// APB: frame_count at byte address 0; write only while no request is open.
module bitmap_frame_allocator_core #(
    parameter int MAX_FRAMES = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bfa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bfa_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int WORDS       = (MAX_FRAMES + 31) / 32;
    localparam int AW          = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W       = 32 - PAGE_SHIFT;
    localparam int LIM_W       = IDX_W + 1;
    localparam int CNT_W       = (LIM_W > bfa_pkg::FRAME_COUNT_W) ? LIM_W : bfa_pkg::FRAME_COUNT_W;
    localparam int ADDR_FRAMES = 1 << IDX_W;
    localparam int CAP         = (MAX_FRAMES < ADDR_FRAMES) ? MAX_FRAMES : ADDR_FRAMES;

    logic [bfa_pkg::FRAME_COUNT_W-1:0] r_frame_count;
    logic                              r_out_valid;
    bfa_pkg::t_out_item                r_out_item;

    logic [CNT_W-1:0]           w_count_ext;
    logic [LIM_W-1:0]           w_limit;
    logic                       w_res_valid;
    logic                       w_res_ready;
    bfa_pkg::t_out_item         w_res;
    logic                       w_wr_en;
    logic [AW-1:0]              w_wr_addr;
    logic [bfa_pkg::WORD_W-1:0] w_wr_data;
    logic                       w_rd_en;
    logic [AW-1:0]              w_rd_addr;
    logic [bfa_pkg::WORD_W-1:0] w_rd_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= bfa_pkg::FRAME_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == bfa_pkg::REG_FRAME_COUNT) begin
            r_frame_count <= pwdata[bfa_pkg::FRAME_COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bfa_pkg::REG_FRAME_COUNT) begin
            prdata = 32'(r_frame_count);
        end
    end

    // clamp to the RAM size and to frames whose address fits in 32 bits
    always_comb begin
        w_count_ext = CNT_W'(r_frame_count);
        if (w_count_ext > CNT_W'(CAP)) begin
            w_limit = LIM_W'(CAP);
        end else begin
            w_limit = w_count_ext[LIM_W-1:0];
        end
    end

    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bfa_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .WORDS      (WORDS),
        .AW         (AW),
        .LIM_W      (LIM_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_limit       (w_limit),
        .i_req_valid   (i_in_valid),
        .o_req_ready   (o_in_ready),
        .i_req         (i_in_item),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_mem_wr_en   (w_wr_en),
        .o_mem_wr_addr (w_wr_addr),
        .o_mem_wr_data (w_wr_data),
        .o_mem_rd_en   (w_rd_en),
        .o_mem_rd_addr (w_rd_addr),
        .i_mem_rd_data (w_rd_data)
    );

    bfa_ram #(
        .WIDTH (bfa_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

>>> hw/rtl/bfa_ram.sv
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/bfa_ctrl.sv
`include "bitmap_frame_allocator_core_assert.svh"

module bfa_ctrl #(
    parameter int MAX_FRAMES = 4096,
    parameter int PAGE_SHIFT = 12,
    parameter int WORDS      = (MAX_FRAMES + 31) / 32,
    parameter int AW         = (WORDS > 1) ? $clog2(WORDS) : 1,
    parameter int LIM_W      = 32 - PAGE_SHIFT + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [LIM_W-1:0]              i_limit,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  bfa_pkg::t_in_item             i_req,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output bfa_pkg::t_out_item            o_res,
    output logic                          o_mem_wr_en,
    output logic [AW-1:0]                 o_mem_wr_addr,
    output logic [bfa_pkg::WORD_W-1:0]    o_mem_wr_data,
    output logic                          o_mem_rd_en,
    output logic [AW-1:0]                 o_mem_rd_addr,
    input  logic [bfa_pkg::WORD_W-1:0]    i_mem_rd_data
);

    localparam int IDX_W = 32 - PAGE_SHIFT;
    localparam int PW    = $clog2(WORDS + 1);
    localparam int FW    = AW + 5;
    localparam int CW    = (FW > LIM_W) ? FW : LIM_W;

    bfa_pkg::t_state n_state;
    bfa_pkg::t_state r_state;

    logic [PW-1:0]    r_ptr;
    logic             r_dv;
    logic [AW-1:0]    r_daddr;
    logic [1:0]       r_op;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_res_addr;
    logic [1:0]       r_res_status;

    logic [IDX_W-1:0] w_req_idx;
    logic             w_req_in_range;
    logic             w_hit;
    logic             w_last;
    logic [4:0]       w_pos;
    logic [CW-1:0]    w_frame;
    logic             w_fits;
    logic             w_scan_rd;
    logic [CW-1:0]    w_idx_ext;
    logic [AW-1:0]    w_idx_word;
    logic [31:0]      w_idx_bit;
    logic             w_accept;

    // datapath
    always_comb begin
        w_req_idx      = i_req.frame_addr[31:PAGE_SHIFT];
        w_req_in_range = CW'(w_req_idx) < CW'(i_limit);
        w_hit          = r_dv && (i_mem_rd_data != '1);
        w_last         = r_dv && (r_daddr == AW'(WORDS - 1));
        w_pos          = bfa_pkg::first_zero(i_mem_rd_data);
        w_frame        = CW'({r_daddr, w_pos});
        w_fits         = w_frame < CW'(i_limit);
        w_scan_rd      = (r_state == bfa_pkg::ST_SCAN) && (r_ptr < PW'(WORDS)) && !w_hit;
        w_idx_ext      = CW'(r_idx);
        w_idx_word     = w_idx_ext[AW+4:5];
        w_idx_bit      = 32'd1 << r_idx[4:0];
        w_accept       = (r_state == bfa_pkg::ST_IDLE) && i_req_valid;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfa_pkg::ST_CLEAR: begin
                if (r_ptr == PW'(WORDS - 1)) begin
                    n_state = bfa_pkg::ST_IDLE;
                end
            end
            bfa_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    priority case (i_req.opcode)
                        bfa_pkg::OP_ALLOC: n_state = bfa_pkg::ST_SCAN;
                        bfa_pkg::OP_FREE,
                        bfa_pkg::OP_RESERVE: begin
                            n_state = w_req_in_range ? bfa_pkg::ST_READ : bfa_pkg::ST_DONE;
                        end
                        default: n_state = bfa_pkg::ST_DONE;
                    endcase
                end
            end
            bfa_pkg::ST_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = bfa_pkg::ST_DONE;
                end
            end
            bfa_pkg::ST_READ:   n_state = bfa_pkg::ST_MODIFY;
            bfa_pkg::ST_MODIFY: n_state = bfa_pkg::ST_DONE;
            bfa_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = bfa_pkg::ST_IDLE;
                end
            end
            default: n_state = bfa_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready   = 1'b0;
        o_res_valid   = 1'b0;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = w_idx_word;
        o_mem_wr_data = '0;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = w_idx_word;
        unique case (r_state)
            bfa_pkg::ST_CLEAR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_ptr[AW-1:0];
            end
            bfa_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            bfa_pkg::ST_SCAN: begin
                o_mem_rd_en   = w_scan_rd;
                o_mem_rd_addr = r_ptr[AW-1:0];
                o_mem_wr_en   = w_hit && w_fits;
                o_mem_wr_addr = r_daddr;
                o_mem_wr_data = i_mem_rd_data | (32'd1 << w_pos);
            end
            bfa_pkg::ST_READ: begin
                o_mem_rd_en = 1'b1;
            end
            bfa_pkg::ST_MODIFY: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_data = (r_op == bfa_pkg::OP_FREE) ? (i_mem_rd_data & ~w_idx_bit)
                                                           : (i_mem_rd_data | w_idx_bit);
            end
            bfa_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfa_pkg::ST_CLEAR;
            r_ptr   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= w_scan_rd;
            if (r_state == bfa_pkg::ST_CLEAR || w_scan_rd) begin
                r_ptr <= r_ptr + PW'(1);
            end else if (w_accept) begin
                r_ptr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_daddr <= o_mem_rd_addr;
        if (w_accept) begin
            r_op       <= i_req.opcode;
            r_idx      <= w_req_idx;
            r_res_addr <= '0;
            if ((i_req.opcode == bfa_pkg::OP_FREE || i_req.opcode == bfa_pkg::OP_RESERVE)
                    && !w_req_in_range) begin
                r_res_status <= bfa_pkg::STAT_RANGE;
            end else begin
                r_res_status <= bfa_pkg::STAT_DONE;
            end
        end else if (r_state == bfa_pkg::ST_SCAN) begin
            // the lowest clear bit decides, even when it lies above the limit
            if (w_hit && w_fits) begin
                r_res_addr   <= {w_frame[IDX_W-1:0], {PAGE_SHIFT{1'b0}}};
                r_res_status <= bfa_pkg::STAT_DONE;
            end else if (w_hit || w_last) begin
                r_res_status <= bfa_pkg::STAT_NO_FREE;
            end
        end
    end

    assign o_res.alloc_addr = r_res_addr;
    assign o_res.status     = r_res_status;

    `BFA_ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != bfa_pkg::ST_IDLE)
    `BFA_ASSERT_IMP(a_modify_after_read, r_state == bfa_pkg::ST_MODIFY, $past(r_state) == bfa_pkg::ST_READ)
    `BFA_ASSERT_IMP(a_fail_has_no_addr, o_res_valid && o_res.status != bfa_pkg::STAT_DONE, o_res.alloc_addr == 32'd0)
    `BFA_ASSERT_IMP(a_scan_write_below_limit, r_state == bfa_pkg::ST_SCAN && o_mem_wr_en, w_fits && w_hit)

endmodule

>>> test/tb.sv
module tb;
    import bfa_pkg::*;

    localparam int MAX_FRAMES = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int RAND_ITEMS = 1700;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] FRAME_COUNT_ADDR = {REG_FRAME_COUNT, 2'b00};

    typedef struct packed {
        bit          reg_write;
        logic [1:0]  op;
        logic [31:0] arg;
        bit          typed;
        logic [31:0] want_addr;
        logic [1:0]  want_status;
    } t_script_row;

    typedef struct packed {
        logic [12:0] count;
        int          window;
        int          items;
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [MAX_FRAMES-1:0] used_frames = '0;
    logic [12:0]           managed_frames = FRAME_COUNT_RESET;
    t_out_item             pending_results[$];
    t_out_item             head_result;
    int                    errors = 0;
    int                    gap_pct = 10;
    int                    stall_pct = 75;

    t_script_row script_rows [26] = '{
        '{1'b0, OP_ALLOC,   32'h0000_0000, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_ALLOC,   32'h0000_0000, 1'b1, 32'h0000_1000, STAT_DONE},
        '{1'b0, OP_FREE,    32'h0000_0FFF, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_FREE,    32'h0000_0000, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_ALLOC,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_RESERVE, 32'h0000_2ABC, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_RESERVE, 32'h0000_2000, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_ALLOC,   32'h0000_0000, 1'b0, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_FREE,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_RANGE},
        '{1'b0, OP_RESERVE, 32'h0100_0000, 1'b1, 32'h0000_0000, STAT_RANGE},
        '{1'b0, OP_RESERVE, 32'h00FF_F000, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_FREE,    32'h00FF_FFFF, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_UNUSED,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_ALLOC,   32'h0000_0000, 1'b0, 32'h0000_0000, STAT_DONE},
        '{1'b1, OP_ALLOC,   32'd0,         1'b0, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_ALLOC,   32'h0000_0000, 1'b1, 32'h0000_0000, STAT_NO_FREE},
        '{1'b0, OP_FREE,    32'h0000_0000, 1'b1, 32'h0000_0000, STAT_RANGE},
        '{1'b1, OP_ALLOC,   32'd5,         1'b0, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_ALLOC,   32'h0000_0000, 1'b1, 32'h0000_0000, STAT_NO_FREE},
        '{1'b0, OP_RESERVE, 32'h0000_5000, 1'b1, 32'h0000_0000, STAT_RANGE},
        '{1'b0, OP_FREE,    32'h0000_1000, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_ALLOC,   32'h0000_0000, 1'b0, 32'h0000_0000, STAT_DONE},
        '{1'b1, OP_ALLOC,   32'd8191,      1'b0, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_RESERVE, 32'h00FF_FFFF, 1'b1, 32'h0000_0000, STAT_DONE},
        '{1'b0, OP_RESERVE, 32'h0100_0000, 1'b1, 32'h0000_0000, STAT_RANGE},
        '{1'b0, OP_ALLOC,   32'h0000_0000, 1'b0, 32'h0000_0000, STAT_DONE}
    };

    // frame count, frame window for free/reserve targets, requests
    t_phase phases [9] = '{
        '{13'd4096, 300,  250},
        '{13'd1,    1,    120},
        '{13'd40,   40,   200},
        '{13'd0,    0,    60},
        '{13'd97,   97,   200},
        '{13'd8191, 1024, 250},
        '{13'd4095, 4095, 200},
        '{13'd300,  300,  220},
        '{13'd4096, 4096, 200}
    };

    bitmap_frame_allocator_core #(
        .MAX_FRAMES(MAX_FRAMES),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int active_frames();
        return (managed_frames > MAX_FRAMES) ? MAX_FRAMES : int'(managed_frames);
    endfunction

    // first fit over the frames below the active count; free and reserve clear or set a bit
    function automatic t_out_item predict_frame_op(input t_in_item req);
        t_out_item res;
        int        limit;
        int        idx;
        bit        found;
        res = '0;
        res.status = STAT_DONE;
        limit = active_frames();
        idx = int'(req.frame_addr >> PAGE_SHIFT);
        found = 1'b0;
        case (req.opcode)
            OP_ALLOC: begin
                res.status = STAT_NO_FREE;
                for (int f = 0; f < limit; f++) begin
                    if (!found && !used_frames[f]) begin
                        found = 1'b1;
                        used_frames[f] = 1'b1;
                        res.alloc_addr = 32'(f) << PAGE_SHIFT;
                        res.status = STAT_DONE;
                    end
                end
            end
            OP_FREE, OP_RESERVE: begin
                if (idx >= limit)
                    res.status = STAT_RANGE;
                else
                    used_frames[idx] = (req.opcode == OP_RESERVE);
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_request(input t_in_item req, input bit typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_frame_op(req);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_frame_count(input logic [12:0] count);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        // upper data bits are outside the register and must be dropped
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= FRAME_COUNT_ADDR;
        pwdata <= {19'($urandom), count};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        managed_frames = count;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none got %h", $time, o_out_item);
                errors++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_out_item.alloc_addr !== head_result.alloc_addr) begin
                    $display("%0t: alloc_addr expected %h got %h", $time,
                             head_result.alloc_addr, o_out_item.alloc_addr);
                    errors++;
                end
                if (o_out_item.status !== head_result.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             head_result.status, o_out_item.status);
                    errors++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        t_in_item  req;
        t_out_item want;
        int        n_sent;
        int        limit;
        int        frame;
        int        r;
        n_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[i]) begin
            if (script_rows[i].reg_write) begin
                write_frame_count(script_rows[i].arg[12:0]);
            end else begin
                req.opcode = script_rows[i].op;
                req.frame_addr = script_rows[i].arg;
                want.alloc_addr = script_rows[i].want_addr;
                want.status = script_rows[i].want_status;
                push_request(req, script_rows[i].typed, want);
            end
        end

        foreach (phases[p]) begin
            write_frame_count(phases[p].count);
            limit = active_frames();
            for (int k = 0; k < phases[p].items; k++) begin
                if (n_sent < RAND_ITEMS / 3) begin
                    gap_pct = 10;
                    stall_pct = 75;
                end else if (n_sent < 2 * RAND_ITEMS / 3) begin
                    gap_pct = 75;
                    stall_pct = 10;
                end else begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                r = $urandom_range(99);
                if (r < 40)
                    req.opcode = OP_ALLOC;
                else if (r < 68)
                    req.opcode = OP_FREE;
                else if (r < 94)
                    req.opcode = OP_RESERVE;
                else
                    req.opcode = OP_UNUSED;
                r = $urandom_range(99);
                if (r < 8) begin
                    req.frame_addr = $urandom;
                end else begin
                    // hit just above the count, the last frame, or the working window
                    if (r < 20)
                        frame = limit + $urandom_range(63);
                    else if (r < 26 && limit > 0)
                        frame = limit - 1;
                    else if (phases[p].window > 0)
                        frame = $urandom_range(phases[p].window - 1);
                    else
                        frame = 0;
                    req.frame_addr = (32'(frame) << PAGE_SHIFT) | 32'($urandom_range(4095));
                end
                want = '0;
                push_request(req, 1'b0, want);
                n_sent++;
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_ram.sv
hw/rtl/bfa_ctrl.sv
hw/rtl/bitmap_frame_allocator_core.sv
test/tb.sv
